// ----- sv/assert_macros.svh -----
// Assertion helpers for the bound checker module hse_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hse_pkg.sv -----
`default_nettype none

package hse_pkg;

    // Code geometry
    localparam int CODE_BITS  = 32;
    localparam int CHECK_BITS = 5;
    localparam int DATA_BITS  = CODE_BITS - CHECK_BITS - 1;
    localparam int BYTE_BITS  = 8;
    localparam int POS_W      = $clog2(CODE_BITS);
    localparam int COUNT_W    = $clog2(DATA_BITS);

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 end_of_data;
    } hse_in_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] codeword;
        logic                 last_word;
    } hse_out_t;

    // Groups handed from the packer to the encoders
    typedef struct packed {
        logic [1:0]           n;
        logic [DATA_BITS-1:0] group0;
        logic                 last0;
        logic [DATA_BITS-1:0] group1;
        logic                 last1;
    } hse_group_push_t;

    // Encoded words pushed into the output queue
    typedef struct packed {
        logic [1:0] n;
        hse_out_t   item0;
        hse_out_t   item1;
    } hse_word_push_t;

    // True where position p carries a check bit (p+1 a power of two)
    function automatic logic hse_is_check(input int p);
        int q;
        q = p + 1;
        return ((q & (q - 1)) == 0) && (q < (1 << CHECK_BITS));
    endfunction

    // Codeword position of the k-th data bit
    function automatic logic [POS_W-1:0] hse_data_pos(input int k);
        int cnt;
        logic [POS_W-1:0] pos;
        cnt = 0;
        pos = '0;
        for (int p = 0; p < CODE_BITS - 1; p++) begin
            if (!hse_is_check(p)) begin
                if (cnt == k) begin
                    pos = POS_W'(p);
                end
                cnt++;
            end
        end
        return pos;
    endfunction

    // Positions covered by check bit i
    function automatic logic [CODE_BITS-2:0] hse_cover(input int i);
        logic [CODE_BITS-2:0] m;
        m = '0;
        for (int p = 0; p < CODE_BITS - 1; p++) begin
            m[p] = 1'((p + 1) >> i);
        end
        return m;
    endfunction

    // True when every check and the overall parity hold
    function automatic logic hse_word_ok(input logic [CODE_BITS-1:0] cw);
        logic ok;
        ok = ~(^cw);
        for (int i = 0; i < CHECK_BITS; i++) begin
            if (^(cw[CODE_BITS-2:0] & hse_cover(i))) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hse_encode.sv -----
`default_nettype none

module hse_encode
    import hse_pkg::*;
(
    input  wire logic [DATA_BITS-1:0] group,
    output logic      [CODE_BITS-1:0] codeword
);

    logic [CODE_BITS-1:0] data_word;
    logic [CODE_BITS-1:0] check_word;

    // Scatter the group over the data positions
    always_comb
    begin
        data_word = '0;
        for (int k = 0; k < DATA_BITS; k++) begin
            data_word[hse_data_pos(k)] = group[k];
        end
    end

    // Compute each check bit from the data bits it covers
    always_comb
    begin
        check_word = data_word;
        for (int i = 0; i < CHECK_BITS; i++) begin
            check_word[(1 << i) - 1] = ^(data_word[CODE_BITS-2:0] & hse_cover(i));
        end
    end

    // Add overall parity in the last position
    assign codeword = {^check_word[CODE_BITS-2:0], check_word[CODE_BITS-2:0]};

endmodule

`default_nettype wire

// ----- sv/hse_pack.sv -----
`default_nettype none

module hse_pack
    import hse_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire hse_in_t in_data,
    input  wire logic    room,
    output hse_group_push_t push
);

    logic                 in_valid_reg;
    hse_in_t              in_reg;
    logic [DATA_BITS-1:0] pending_bits_reg;
    logic [DATA_BITS-1:0] pending_bits_next;
    logic [COUNT_W-1:0]   pending_count_reg;
    logic [COUNT_W-1:0]   pending_count_next;

    logic                           go;
    logic [BYTE_BITS-1:0]           rev_byte;
    logic [DATA_BITS+BYTE_BITS-1:0] combined;
    logic [COUNT_W:0]               total;
    logic                           full;
    logic [DATA_BITS-1:0]           bits_after;
    logic [COUNT_W-1:0]             count_after;
    logic                           partial;

    assign go       = in_valid_reg && room;
    assign in_ready = !in_valid_reg || go;

    // Hold the accepted transaction until the queue has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            in_reg <= in_data;
        end
    end

    // Put the byte in stream order, most significant bit first
    always_comb
    begin
        for (int j = 0; j < BYTE_BITS; j++) begin
            rev_byte[j] = in_reg.data_byte[BYTE_BITS-1-j];
        end
    end

    // Append the byte behind the pending bits and cut a full group
    always_comb
    begin
        combined = {{BYTE_BITS{1'b0}}, pending_bits_reg}
                 | ({{DATA_BITS{1'b0}}, rev_byte} << pending_count_reg);
        total    = {1'b0, pending_count_reg} + (COUNT_W+1)'(BYTE_BITS);
        full     = total >= (COUNT_W+1)'(DATA_BITS);
        if (full) begin
            bits_after  = DATA_BITS'(combined >> DATA_BITS);
            count_after = COUNT_W'(total - (COUNT_W+1)'(DATA_BITS));
        end else begin
            bits_after  = combined[DATA_BITS-1:0];
            count_after = total[COUNT_W-1:0];
        end
        partial = in_reg.end_of_data && (count_after != '0);
    end

    // Form up to two groups for the encoders
    always_comb
    begin
        push.n      = go ? (2'(full) + 2'(partial)) : 2'd0;
        push.group0 = full ? combined[DATA_BITS-1:0] : bits_after;
        push.last0  = in_reg.end_of_data && !(full && partial);
        push.group1 = bits_after;
        push.last1  = in_reg.end_of_data;
    end

    // Advance the pending group; drop it at end of data
    always_comb
    begin
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        if (go) begin
            if (in_reg.end_of_data) begin
                pending_bits_next  = '0;
                pending_count_next = '0;
            end else begin
                pending_bits_next  = bits_after;
                pending_count_next = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
        end else begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hse_out_fifo.sv -----
`default_nettype none

module hse_out_fifo
    import hse_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hse_word_push_t push,
    output logic                room,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hse_out_t            out_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    hse_out_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;
    logic               pop;

    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = count_reg <= (PTR_W+1)'(DEPTH - 2);

    // Write up to two entries per cycle
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.item1;
        end
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push.n) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hamming_secded_block_encoder.sv -----
// Channel | Direction | Payload    | Handshake
// in      | input     | hse_in_t   | in_valid / in_ready
// out     | output    | hse_out_t  | out_valid / out_ready
//
// One byte is taken per cycle while in_ready is high. A group's closing byte
// waits in the input register, then its codeword enters the four-entry queue.
// A final byte that both closes a group and leaves spare bits yields two
// codewords, which the queue drains one per cycle while out_ready is high.
// Reset empties the input register, the pending group and the output queue.
// in_ready drops while the input register holds a byte and the queue has
// fewer than two free entries.
`default_nettype none

module hamming_secded_block_encoder
    import hse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire hse_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output hse_out_t      out_data
);

    hse_group_push_t group_push;
    hse_word_push_t  word_push;
    logic            room;
    logic [CODE_BITS-1:0] codeword0;
    logic [CODE_BITS-1:0] codeword1;

    // Pack bytes into groups
    hse_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .room     (room),
        .push     (group_push)
    );

    // Encode both candidate groups
    hse_encode u_encode0 (
        .group    (group_push.group0),
        .codeword (codeword0)
    );

    hse_encode u_encode1 (
        .group    (group_push.group1),
        .codeword (codeword1)
    );

    always_comb
    begin
        word_push.n               = group_push.n;
        word_push.item0.codeword  = codeword0;
        word_push.item0.last_word = group_push.last0;
        word_push.item1.codeword  = codeword1;
        word_push.item1.last_word = group_push.last1;
    end

    // Queue codewords toward the output
    hse_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (word_push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- sv/hse_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module hse_checker
    import hse_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire hse_in_t  in_data,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire hse_out_t out_data
);

    // Hold a stalled input transaction
    `ASSERT_NEXT(a_in_hold, clk, rst_n,
                 in_valid && !in_ready, in_valid && $stable(in_data), "input changed while stalled")

    // Hold a stalled output transaction
    `ASSERT_NEXT(a_out_valid_hold, clk, rst_n,
                 out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
    `ASSERT_NEXT(a_out_data_hold, clk, rst_n,
                 out_valid && !out_ready, $stable(out_data), "out_data changed while stalled")

    // Every codeword leaves with even overall parity
    `ASSERT_IMPL(a_overall_parity, clk, rst_n,
                 out_valid, ^out_data.codeword == 1'b0, "overall parity odd")

    // Every codeword leaves with a zero syndrome
    `ASSERT_IMPL(a_syndrome_zero, clk, rst_n,
                 out_valid, hse_word_ok(out_data.codeword), "nonzero syndrome")

endmodule

bind hamming_secded_block_encoder hse_checker u_hse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ----- dv/hamming_secded_block_encoder_checker.sv -----
`timescale 1ns / 1ps

module hamming_secded_block_encoder_checker
    import hse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  hse_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  hse_out_t out_data,
    output int       errors,
    output int       outstanding
);

    localparam int PRINT_CAP = 40;

    hse_out_t             expected_words[$];
    logic [DATA_BITS-1:0] group_bits;
    int                   group_fill;

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    // Place the group's bits, then fill in the check bits and the overall parity
    function automatic logic [CODE_BITS-1:0] encode_group(input logic [DATA_BITS-1:0] g);
        logic [CODE_BITS-1:0] w;
        int                   k;
        int                   chk_pos;
        logic                 par;
        w = '0;
        k = 0;
        for (int p = 0; p < CODE_BITS - 1; p++)
        begin
            if (!((((p + 1) & p) == 0) && ((p + 1) < (1 << CHECK_BITS))))
            begin
                if (k < DATA_BITS)
                begin
                    w[p] = g[k];
                end
                k++;
            end
        end
        for (int i = 0; i < CHECK_BITS; i++)
        begin
            chk_pos = (1 << i) - 1;
            if (chk_pos + 1 < CODE_BITS)
            begin
                par = 1'b0;
                for (int p = 0; p < CODE_BITS - 1; p++)
                begin
                    if ((((p + 1) >> i) & 1) != 0)
                    begin
                        par = par ^ w[p];
                    end
                end
                if (par)
                begin
                    w[chk_pos] = 1'b1;
                end
            end
        end
        w[CODE_BITS-1] = ^w[CODE_BITS-2:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < PRINT_CAP)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        errors++;
    endtask

    // Shift one byte into the open group, most significant bit first
    task automatic absorb_byte(input hse_in_t item);
        hse_out_t word;
        bit       made;
        made = 1'b0;
        for (int b = BYTE_BITS - 1; b >= 0; b--)
        begin
            group_bits[group_fill] = item.data_byte[b];
            group_fill++;
            if (group_fill == DATA_BITS)
            begin
                if (!made)
                begin
                    word.codeword  = encode_group(group_bits);
                    word.last_word = 1'b0;
                    expected_words.push_back(word);
                    made = 1'b1;
                end
                group_bits = '0;
                group_fill = 0;
            end
        end
        // Flush a padded partial group and mark the message's final word
        if (item.end_of_data)
        begin
            if (group_fill > 0)
            begin
                word.codeword  = encode_group(group_bits);
                word.last_word = 1'b0;
                expected_words.push_back(word);
                made = 1'b1;
            end
            if (made)
            begin
                expected_words[expected_words.size()-1].last_word = 1'b1;
            end
            group_bits = '0;
            group_fill = 0;
        end
    endtask

    task automatic check_word(input hse_out_t got);
        hse_out_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected codeword %08h", got.codeword));
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.codeword !== want.codeword)
            begin
                report_mismatch($sformatf("codeword %08h, want %08h",
                                          got.codeword, want.codeword));
            end
            if (got.last_word !== want.last_word)
            begin
                report_mismatch($sformatf("last_word %b, want %b on codeword %08h",
                                          got.last_word, want.last_word, want.codeword));
            end
        end
    endtask

    // Sample both channels at the clock edge; inputs first, then results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            group_bits  = '0;
            group_fill  = 0;
            outstanding = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_byte(in_data);
            end
            if (out_valid && out_ready)
            begin
                check_word(out_data);
            end
            outstanding = expected_words.size();
        end
    end

    // Anything still queued at the end is reported by the top
    final
    begin
    end

endmodule

// ----- dv/hamming_secded_block_encoder_tb.sv -----
`timescale 1ns / 1ps

module hamming_secded_block_encoder_tb;
    import hse_pkg::*;

    localparam int BYTE_TARGET  = 1900;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    hse_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    hse_out_t out_data;

    int       errors;
    int       outstanding;
    int       bytes_sent   = 0;
    bit       rush         = 1'b0;
    bit       hold_request = 1'b0;

    hamming_secded_block_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    hamming_secded_block_encoder_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return BYTE_BITS'($urandom);
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic push_byte(input logic [BYTE_BITS-1:0] value, input logic eod);
        int gap;
        gap = rush ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        in_data.data_byte   <= value;
        in_data.end_of_data <= eod;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_message(input int len, input bit closed);
        for (int i = 0; i < len; i++)
        begin
            push_byte(pick_byte(), closed && (i == len - 1));
        end
    endtask

    // Receiver: random back-pressure, with one long hold-off on request
    initial
    begin
        int off;
        int on;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                off = pick_gap();
                on  = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 8);
                if (off > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (off) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat (on) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        bit hold_done;
        bit drain_done;
        int len;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte messages: padded partial group only
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b1);
        // Final byte closes a group and leaves spare bits: two codewords
        for (int i = 0; i < 4; i++)
        begin
            push_byte(8'hFF, i == 3);
        end
        // Thirteen bytes: the final byte completes a group exactly
        for (int i = 0; i < 13; i++)
        begin
            push_byte((i % 2 == 0) ? 8'hAA : 8'h55, i == 12);
        end

        // Random messages, mostly closed, some running into the next one
        while (bytes_sent < BYTE_TARGET)
        begin
            rush = ($urandom_range(0, 5) == 0);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 80)
                                               : $urandom_range(1, 30);
            if (!hold_done && bytes_sent > 600)
            begin
                // Stall the output long enough to back the block up
                hold_done    = 1'b1;
                rush         = 1'b1;
                hold_request = 1'b1;
                len          = 60;
            end
            if (!drain_done && bytes_sent > 1200)
            begin
                // Pause the sender until every codeword is out
                drain_done = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
            send_message(len, $urandom_range(0, 19) != 0);
        end
        rush = 1'b0;
        send_message(5, 1'b1);
        in_valid <= 1'b0;

        // Drain the expected codewords, then allow for pipeline latency
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && outstanding == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- hamming_secded_block_encoder.f -----
+incdir+sv
sv/hse_pkg.sv
sv/hse_encode.sv
sv/hse_pack.sv
sv/hse_out_fifo.sv
sv/hamming_secded_block_encoder.sv
sv/hse_checker.sv
dv/hamming_secded_block_encoder_checker.sv
dv/hamming_secded_block_encoder_tb.sv
